// ===== hdl/utca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utca_pkg
// Shared widths, constants and command/status types for the trace cost block.
// ----------------------------------------------------------------------------
package utca_pkg;

    localparam int ACC_W  = 40;
    localparam int ELEM_W = 18;
    localparam int COST_W = 19;
    localparam int ROW_W  = 11;
    localparam int COL_W  = 10;
    localparam int QC_W   = 4;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_HS     = 2'd1;
    localparam logic [1:0] MODE_INFID  = 2'd2;

    localparam logic [1:0] REG_QUBITS = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accum;     // add the input transaction into the sums
        logic snap;      // latch sums for the cost pass and clear them
        logic cost_a;    // step 1: divide trace by N, square terms
        logic cost_b;    // step 2: sum squares, round, clamp
        logic cost_c;    // step 3: N*p + 1
        logic div_start; // start the serial divider
        logic div_step;  // one restoring division step
        logic cost_fin;  // form the final cost and load the output register
    } utca_cmd_t;

    typedef struct packed {
        logic div_done;
    } utca_sts_t;

endpackage

// ===== hdl/utca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utca_ctrl
// Sequencer: accepts elements, runs the cost pass on the last one, hands off
// to the output register.
// ----------------------------------------------------------------------------
module utca_ctrl
    import utca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_last,
    output logic      in_ready,
    input  logic      out_busy,
    input  logic      out_take,
    output utca_cmd_t cmd,
    input  utca_sts_t sts
);

    typedef enum logic [2:0] {
        ST_RUN, ST_A, ST_B, ST_C, ST_DIV, ST_FIN, ST_WAIT
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == ST_RUN);

    always_comb
    begin
        cmd           = '0;
        cmd.accum     = in_ready && in_valid;
        cmd.snap      = in_ready && in_valid && in_last;
        cmd.cost_a    = (state_reg == ST_A);
        cmd.cost_b    = (state_reg == ST_B);
        cmd.cost_c    = (state_reg == ST_C);
        cmd.div_start = (state_reg == ST_C);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.cost_fin  = (state_reg == ST_FIN) && (!out_busy || out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:  if (cmd.snap) state_reg <= ST_A;
                ST_A:    state_reg <= ST_B;
                ST_B:    state_reg <= ST_C;
                ST_C:    state_reg <= ST_DIV;
                ST_DIV:  if (sts.div_done) state_reg <= ST_FIN;
                ST_FIN:  if (cmd.cost_fin) state_reg <= ST_RUN;
                default: state_reg <= ST_RUN;
            endcase
        end
    end

endmodule

// ===== hdl/utca_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utca_dp
// Accumulators, element classification and the cost arithmetic, including a
// restoring divider by N+1.
// ----------------------------------------------------------------------------
module utca_dp
    import utca_pkg::*;
#(
    parameter int MAX_QUBITS = 10,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  utca_cmd_t                cmd,
    output utca_sts_t                sts,
    input  logic [QC_W-1:0]          qubit_count,
    input  logic [COL_W-1:0]         row_offset,
    input  logic [1:0]               cost_mode,
    input  logic [ROW_W-1:0]         row_index,
    input  logic [COL_W-1:0]         col_index,
    input  logic signed [ELEM_W-1:0] elem_re,
    input  logic signed [ELEM_W-1:0] elem_im,
    output logic [7*ACC_W-1:0]       sums,
    output logic signed [COST_W-1:0] cost
);

    localparam logic signed [ACC_W-1:0] AMAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] AMIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
    localparam int DIVW = 52;

    logic signed [ACC_W-1:0] tr_re_reg, tr_im_reg, s1_re_reg, s1_im_reg;
    logic signed [ACC_W-1:0] s2_re_reg, s2_im_reg;
    logic [ACC_W-1:0] sq_reg;
    logic signed [ACC_W-1:0] c_re_reg, c_im_reg;

    logic [3:0] q;
    always_comb
    begin
        if (qubit_count == '0) q = 4'd1;
        else if (32'(qubit_count) > MAX_QUBITS) q = 4'(MAX_QUBITS);
        else q = qubit_count;
    end

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a, input logic signed [ELEM_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-ELEM_W){b[ELEM_W-1]}}, b};
        if (s > $signed({AMAX[ACC_W-1], AMAX})) return AMAX;
        if (s < $signed({AMIN[ACC_W-1], AMIN})) return AMIN;
        return s[ACC_W-1:0];
    endfunction

    // Classification.
    logic [11:0] dsum, d, lowm;
    logic [3:0]  pc;
    always_comb
    begin
        dsum = 12'(col_index) + 12'(row_offset);
        d    = 12'(row_index) ^ dsum;
        lowm = (12'd1 << q) - 12'd1;
        pc   = '0;
        for (int i = 0; i < 12; i++) pc = pc + 4'(d[i]);
    end
    wire is_tr = (d == '0);
    wire in_lo = ((d & ~lowm) == '0) && !is_tr;
    wire is_s1 = in_lo && (pc == 4'd1);
    wire is_s2 = in_lo && (pc == 4'd2);

    // Squared distance to identity.
    logic signed [19:0] ure_s;
    logic [18:0] ure, uim;
    logic [38:0] sqt;
    logic [ACC_W:0] sq_sum;
    always_comb
    begin
        ure_s = 20'(elem_re) - ((12'(row_index) == 12'(col_index)) ?
                20'(ONE) : 20'sd0);
        ure = ure_s[19] ? 19'(-ure_s) : 19'(ure_s);
        uim = elem_im[ELEM_W-1] ? 19'(-20'(elem_im)) : 19'(elem_im);
        sqt = 39'((39'(ure) * 39'(ure) + 39'(uim) * 39'(uim) +
              (39'd1 << (FRAC_BITS-1))) >> FRAC_BITS);
        sq_sum = {1'b0, sq_reg} + (ACC_W+1)'(sqt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tr_re_reg <= '0; tr_im_reg <= '0; s1_re_reg <= '0; s1_im_reg <= '0;
            s2_re_reg <= '0; s2_im_reg <= '0; sq_reg <= '0;
        end
        else if (cmd.snap)
        begin
            tr_re_reg <= '0; tr_im_reg <= '0; s1_re_reg <= '0; s1_im_reg <= '0;
            s2_re_reg <= '0; s2_im_reg <= '0; sq_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (is_tr)
            begin
                tr_re_reg <= sat_add(tr_re_reg, elem_re);
                tr_im_reg <= sat_add(tr_im_reg, elem_im);
            end
            if (is_s1)
            begin
                s1_re_reg <= sat_add(s1_re_reg, elem_re);
                s1_im_reg <= sat_add(s1_im_reg, elem_im);
            end
            if (is_s2)
            begin
                s2_re_reg <= sat_add(s2_re_reg, elem_re);
                s2_im_reg <= sat_add(s2_im_reg, elem_im);
            end
            sq_reg <= sq_sum[ACC_W] ? {ACC_W{1'b1}} : sq_sum[ACC_W-1:0];
        end
    end

    // Snapshot of final sums including the last element.
    logic [7*ACC_W-1:0] snap_reg;
    logic [3:0] q_reg;
    logic [1:0] mode_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            snap_reg <= {(sq_sum[ACC_W] ? {ACC_W{1'b1}} : sq_sum[ACC_W-1:0]),
                         (is_s2 ? sat_add(s2_im_reg, elem_im) : s2_im_reg),
                         (is_s2 ? sat_add(s2_re_reg, elem_re) : s2_re_reg),
                         (is_s1 ? sat_add(s1_im_reg, elem_im) : s1_im_reg),
                         (is_s1 ? sat_add(s1_re_reg, elem_re) : s1_re_reg),
                         (is_tr ? sat_add(tr_im_reg, elem_im) : tr_im_reg),
                         (is_tr ? sat_add(tr_re_reg, elem_re) : tr_re_reg)};
            q_reg    <= q;
            mode_reg <= cost_mode;
        end
    end
    assign sums = snap_reg;
    always_comb
    begin
        c_re_reg = snap_reg[ACC_W-1:0];
        c_im_reg = snap_reg[2*ACC_W-1:ACC_W];
    end

    // Step A: rounded divide by N, magnitude clamp, squares split 32x32.
    function automatic logic signed [ACC_W-1:0] rdiv(
        input logic signed [ACC_W-1:0] x, input logic [3:0] s);
        logic signed [ACC_W:0] y;
        y = {x[ACC_W-1], x} + ((ACC_W+1)'(1) <<< (s - 4'd1));
        return ACC_W'(y >>> s);
    endfunction

    logic signed [ACC_W-1:0] a_reg, a_d, b_d;
    logic [31:0] ua, ub;
    logic [63:0] ua2_reg, ub2_reg;
    logic ua_top, ub_top;
    always_comb
    begin
        a_d = rdiv(c_re_reg, q_reg);
        b_d = rdiv(c_im_reg, q_reg);
        ua  = 32'(a_d[ACC_W-1] ? -a_d : a_d);
        ub  = 32'(b_d[ACC_W-1] ? -b_d : b_d);
        // Magnitudes at or above 2^31 clamp to 2^31, whose square is 2^62.
        ua_top = (a_d[ACC_W-1] ? -a_d : a_d) >= (ACC_W'(1) << 31);
        ub_top = (b_d[ACC_W-1] ? -b_d : b_d) >= (ACC_W'(1) << 31);
    end
    always_ff @(posedge clk)
    begin
        if (cmd.cost_a)
        begin
            a_reg   <= a_d;
            ua2_reg <= ua_top ? (64'd1 << 62) : 64'(ua) * 64'(ua);
            ub2_reg <= ub_top ? (64'd1 << 62) : 64'(ub) * 64'(ub);
        end
    end

    // Step B: p = round(a^2 + b^2), clamp.
    logic [64:0] psum;
    logic [48:0] p_d;
    logic [40:0] p_reg;
    always_comb
    begin
        psum = 65'(ua2_reg) + 65'(ub2_reg) + (65'd1 << (FRAC_BITS-1));
        p_d  = 49'(psum >> FRAC_BITS);
    end
    always_ff @(posedge clk)
    begin
        if (cmd.cost_b)
            p_reg <= (p_d > (49'd1 << 40)) ? (41'd1 << 40) : 41'(p_d);
    end

    // Step C and divider: (N*p + 1 + (N+1)/2) / (N+1), restoring, one bit a step.
    logic [DIVW-1:0] num_reg;
    logic [DIVW:0]   rem_reg;
    logic [5:0]      cnt_reg;
    logic [12:0]     den;
    logic [DIVW:0]   trial;
    assign den   = (13'd1 << q_reg) + 13'd1;
    assign trial = {rem_reg[DIVW-1:0], num_reg[DIVW-1]} - (DIVW+1)'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= 6'(DIVW);
        else if (cmd.div_step && cnt_reg != '0)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= (DIVW'(p_reg) << q_reg) + DIVW'(ONE) + DIVW'(den >> 1);
            rem_reg <= '0;
        end
        else if (cmd.div_step && cnt_reg != '0)
        begin
            if (!trial[DIVW])
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[DIVW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DIVW-1:0], num_reg[DIVW-1]};
                num_reg <= {num_reg[DIVW-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = cmd.div_step && (cnt_reg == 6'd1);

    logic signed [ACC_W-1:0] a_lin;
    assign a_lin = a_reg;

    // Final cost; quotient sits in num_reg after the last step.
    logic signed [53:0] c_full;
    always_comb
    begin
        case (mode_reg)
            MODE_LINEAR: c_full = 54'(ONE) - 54'(a_lin);
            MODE_HS:     c_full = 54'(ONE) - 54'(p_reg);
            MODE_INFID:  c_full = 54'(ONE) - 54'(num_reg);
            default:     c_full = '0;
        endcase
        if (c_full > 54'sd262143) cost = 19'sd262143;
        else if (c_full < -54'sd262144) cost = -19'sd262144;
        else cost = c_full[COST_W-1:0];
    end

endmodule

// ===== hdl/unitary_trace_cost_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unitary_trace_cost_accumulator
// Streams matrix elements into trace, flip and distance sums; emits a cost.
// ----------------------------------------------------------------------------
// Ordinary elements: one transaction per cycle, no result.
// Last element: it starts the cost pass (three cost steps, a 52-step serial
// divider by N+1, then a final step that waits for a free output register), and input stalls during that pass.
// Throughput: 1 element per cycle except during the cost pass of each matrix.
// rst_n clears sums and output valid at once and loads register defaults.
module unitary_trace_cost_accumulator
    import utca_pkg::*;
#(
    parameter int MAX_QUBITS = 10,
    parameter int FRAC_BITS  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [9:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // row_index, col_index, elem_re, elem_im
    input  logic         s_axis_tlast,  // last_elem
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // trace_re, trace_im, single_flip_re, single_flip_im, double_flip_re,
    // double_flip_im, sum_squares, cost_value
    output logic [303:0] m_axis_tdata
);

    logic [QC_W-1:0]  qc_reg;
    logic [COL_W-1:0] off_reg;
    logic [1:0]       mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_reg <= 4'd2; off_reg <= '0; mode_reg <= MODE_LINEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_QUBITS: qc_reg   <= cfg_data[QC_W-1:0];
                REG_OFFSET: off_reg  <= cfg_data;
                REG_MODE:   mode_reg <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    utca_cmd_t cmd;
    utca_sts_t sts;
    logic [7*ACC_W-1:0] sums;
    logic signed [COST_W-1:0] cost;
    logic out_take;
    assign out_take = m_axis_tvalid && m_axis_tready;

    utca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .out_busy(m_axis_tvalid), .out_take(out_take),
        .cmd(cmd), .sts(sts)
    );

    utca_dp #(.MAX_QUBITS(MAX_QUBITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .qubit_count(qc_reg), .row_offset(off_reg), .cost_mode(mode_reg),
        .row_index(s_axis_tdata[10:0]), .col_index(s_axis_tdata[20:11]),
        .elem_re(s_axis_tdata[38:21]), .elem_im(s_axis_tdata[56:39]),
        .sums(sums), .cost(cost)
    );

    logic [303:0] out_reg;
    logic         ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.cost_fin)
            ov_reg <= 1'b1;
        else if (out_take)
            ov_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (cmd.cost_fin)
            out_reg <= {5'd0, cost, sums};
    end
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

endmodule

// ===== hdl/utca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utca_checker
// Port-level checks for the trace cost accumulator.
// ----------------------------------------------------------------------------
module utca_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [303:0] m_axis_tdata
);

    // A last element stalls the input for the cost pass.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input not stalled after last element");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A result only follows a last element, never while input is open.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without cost pass");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[303:299] == 5'd0)
        else $error("padding bits set");

endmodule

bind unitary_trace_cost_accumulator utca_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
